>>> src/dtr_pkg.sv
// Shared types and constants for the divider timer with reload.
package dtr_pkg;

   // High byte of the divider after reset; low byte starts at zero.
   localparam logic [7:0] DIVIDER_START_HIGH = 8'd172;

   // Control byte layout.
   localparam int CTRL_ENABLE_BIT = 2;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_CONTROL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DIV_1024 = 2'd0,
      DIV_16   = 2'd1,
      DIV_64   = 2'd2,
      DIV_256  = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic [15:0] divider;
      logic [7:0]  counter;
      logic [10:0] prescaler;
      logic        enabled;
      div_sel_type divisor_select;
   } timer_state_type;

   localparam timer_state_type TIMER_STATE_RESET = '{
      divider:        {DIVIDER_START_HIGH, 8'h00},
      counter:        8'h00,
      prescaler:      11'h000,
      enabled:        1'b0,
      divisor_select: DIV_1024
   };

endpackage

>>> src/dtr_step.sv
// Next-state logic for one tick or control write of the timer.
module dtr_step (
   input  dtr_pkg::timer_state_type state,
   input  logic                     operation,
   input  logic [7:0]               cycles,
   input  logic                     cpu_stopped,
   input  logic [7:0]               write_data,
   input  logic [7:0]               reload_value,
   output dtr_pkg::timer_state_type state_next,
   output logic                     timer_irq
);
   import dtr_pkg::*;

   logic [9:0]  clocks;
   logic [10:0] acc;
   logic [8:0]  quotient;
   logic [10:0] remainder;
   logic [8:0]  count_sum;
   logic        new_enable;

   assign clocks     = {cycles, 2'b00};
   assign acc        = state.prescaler + {1'b0, clocks};
   assign count_sum  = {1'b0, state.counter} + quotient;
   assign new_enable = write_data[CTRL_ENABLE_BIT];

   // power-of-two divisors: quotient and remainder are bit slices
   always_comb begin
      case (state.divisor_select)
         DIV_1024: begin
            quotient  = {8'd0, acc[10]};
            remainder = {1'b0, acc[9:0]};
         end
         DIV_16: begin
            quotient  = {2'd0, acc[10:4]};
            remainder = {7'd0, acc[3:0]};
         end
         DIV_64: begin
            quotient  = {4'd0, acc[10:6]};
            remainder = {5'd0, acc[5:0]};
         end
         DIV_256: begin
            quotient  = {6'd0, acc[10:8]};
            remainder = {3'd0, acc[7:0]};
         end
         default: begin
            quotient  = '0;
            remainder = acc;
         end
      endcase
   end

   always_comb begin
      state_next = state;
      timer_irq  = 1'b0;
      if (operation == OP_CONTROL) begin
         if (new_enable && !state.enabled) begin
            state_next.prescaler = '0;
         end
         state_next.divisor_select = div_sel_type'(write_data[1:0]);
         state_next.enabled        = new_enable;
      end else if (!cpu_stopped) begin
         state_next.divider = state.divider + {6'd0, clocks};
         if (state.enabled) begin
            state_next.prescaler = remainder;
            // carry out of bit 7 means the counter passed 255
            timer_irq            = count_sum[8];
            state_next.counter   = count_sum[8] ? reload_value : count_sum[7:0];
         end
      end
   end

endmodule

>>> src/divider_timer_with_reload_core.sv
// Top level of the divider timer with reload: handshake stages and state.
//
// Request channel (req_*): one transfer per item. operation 0 is a tick that,
// unless cpu_stopped is set, advances the 16-bit divider by req_cycles shifted
// left by two bits and, when enabled, the prescaler and 8-bit counter;
// operation 1 writes the control byte (bits 1:0 divisor select, bit 2 enable).
// Response channel (rsp_*): exactly one transfer per request, in order,
// carrying divider and counter after the item and the overflow pulse.
// CSR port: csr_write_enable/csr_write_data load the reload value; write it
// only while no item is in flight.
// A request is registered in the input stage; when the output register is
// empty or not stalled, its result is computed and loaded into it. Throughput
// is one item per cycle while rsp_stall is low; the timer state feeds back
// through one step of add/shift logic between the two stages.
// Reset (synchronous, active high): divider = DIVIDER_START_HIGH << 8,
// counter, prescaler, enable, divisor select and reload value all zero,
// both stages empty.
// A stalled response holds the output register; the input stage still
// takes one request, then req_stall rises until the output drains.
module divider_timer_with_reload_core (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_cycles,
   input  logic        req_cpu_stopped,
   input  logic [7:0]  req_write_data,
   // response
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_divider_value,
   output logic [7:0]  rsp_counter_value,
   output logic        rsp_timer_irq,
   // config
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import dtr_pkg::*;

   // input stage
   logic            in_valid_ff, in_valid_in;
   logic            op_ff;
   logic [7:0]      cycles_ff;
   logic            stopped_ff;
   logic [7:0]      data_ff;

   // output stage
   logic            out_valid_ff, out_valid_in;
   logic [15:0]     out_divider_ff;
   logic [7:0]      out_counter_ff;
   logic            out_irq_ff;

   // timer state and reload register
   timer_state_type state_ff, state_in;
   logic [7:0]      reload_ff, reload_in;

   timer_state_type step_next;
   logic            step_irq;
   logic            req_accept;
   logic            advance;

   // item moves from input stage to output register
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   dtr_step u_step (
      .state        (state_ff),
      .operation    (op_ff),
      .cycles       (cycles_ff),
      .cpu_stopped  (stopped_ff),
      .write_data   (data_ff),
      .reload_value (reload_ff),
      .state_next   (step_next),
      .timer_irq    (step_irq)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign state_in  = advance ? step_next : state_ff;
   assign reload_in = csr_write_enable ? csr_write_data : reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= TIMER_STATE_RESET;
         reload_ff    <= 8'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         reload_ff    <= reload_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_operation;
         cycles_ff  <= req_cycles;
         stopped_ff <= req_cpu_stopped;
         data_ff    <= req_write_data;
      end
      if (advance) begin
         out_divider_ff <= step_next.divider;
         out_counter_ff <= step_next.counter;
         out_irq_ff     <= step_irq;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_divider_value = out_divider_ff;
   assign rsp_counter_value = out_counter_ff;
   assign rsp_timer_irq     = out_irq_ff;

   // ---- assertions ----

   // input stage only pushes back when it holds an item
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall with empty input stage");

   // every item leaving the input stage shows up at the response port
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("item lost between stages");

   // overflow pulse only on an enabled, running tick
   a_irq_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && step_irq) |->
         (op_ff == OP_TICK && !stopped_ff && state_ff.enabled))
      else $error("timer_irq on non-counting item");

   // control writes leave divider and counter alone
   a_ctrl_keeps_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && op_ff == OP_CONTROL) |=>
         (state_ff.divider == $past(state_ff.divider) &&
          state_ff.counter == $past(state_ff.counter)))
      else $error("control write changed divider or counter");

endmodule
